// ----- src/prsr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// prsr_pkg
// shared constants, state encoding and controller/datapath interface types
// for the priority rotation service rank unit
// ---------------------------------------------------------------------------
package prsr_pkg;

   localparam int MAX_JOBS_DEF      = 128;
   localparam int PRIORITY_BITS_DEF = 4;

   localparam int PRIO_FIELD_W = 4;
   localparam int RANK_FIELD_W = 8;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_START,
      ST_SCAN,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // store the accepted request
      logic init;      // reset the scan engine for a new set
      logic scan;      // run the scan engine
      logic step;      // close a pass and move to the next lower level
      logic capture;   // move the result to the output register, clear the set
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic target_seen;
      logic pass_done;
      logic hit;
      logic no_next;
      logic out_free;
   } sts_type;

endpackage : prsr_pkg
`default_nettype wire

// ----- src/prsr_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// prsr_ctrl
// sequencer: load requests, run one scan pass per priority level, hand the
// result to the output register
// ---------------------------------------------------------------------------
module prsr_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_last_job,
   output logic                   req_stall,
   input  wire prsr_pkg::sts_type sts,
   output prsr_pkg::cmd_type      cmd
);
   import prsr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_last_job) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = sts.target_seen ? ST_SCAN : ST_DONE;
         end
         ST_SCAN: begin
            if (sts.hit || (sts.pass_done && sts.no_next)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_START: begin
            cmd.init = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            cmd.step = sts.pass_done && !sts.hit && !sts.no_next;
         end
         ST_DONE: begin
            cmd.capture = sts.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   a_scan_needs_target: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> sts.target_seen)
      else $error("scan running without a marked job");

   a_start_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_START) |-> $past(cmd.load))
      else $error("set start without a final request");

endmodule : prsr_ctrl
`default_nettype wire

// ----- src/prsr_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// prsr_datapath
// priority store, set registers, level scan engine and output register
// ---------------------------------------------------------------------------
module prsr_datapath #(
   parameter int MAX_JOBS      = prsr_pkg::MAX_JOBS_DEF,
   parameter int PRIORITY_BITS = prsr_pkg::PRIORITY_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire prsr_pkg::cmd_type                     cmd,
   output prsr_pkg::sts_type                          sts,
   input  wire logic [prsr_pkg::PRIO_FIELD_W-1:0]     req_job_priority,
   input  wire logic                                  req_is_target,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [prsr_pkg::RANK_FIELD_W-1:0]          rsp_service_rank,
   output logic                                       rsp_target_found,
   output logic                                       rsp_overflow
);
   import prsr_pkg::*;

   localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CW = $clog2(MAX_JOBS + 1);
   localparam int RW = (CW > RANK_FIELD_W) ? CW : RANK_FIELD_W;
   localparam int PB = PRIORITY_BITS;

   logic [PB-1:0] mem [MAX_JOBS];

   // set registers
   logic [CW-1:0] job_count_ff, job_count_in;
   logic [IW-1:0] target_slot_ff, target_slot_in;
   logic          target_seen_ff, target_seen_in;
   logic          overflow_ff, overflow_in;

   // scan engine
   logic [IW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] issued_ff, issued_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [IW-1:0] rd_slot_ff;
   logic [PB-1:0] rd_data_ff;
   logic          first_ff, first_in;
   logic [PB-1:0] level_ff, level_in;
   logic          have_next_ff, have_next_in;
   logic [PB-1:0] next_ff, next_in;
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] last_ff, last_in;
   logic [CW-1:0] lvl_cnt_ff, lvl_cnt_in;
   logic [CW-1:0] served_ff, served_in;
   logic          hit_ff, hit_in;
   logic [CW-1:0] rank_ff, rank_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RANK_FIELD_W-1:0] rsp_rank_ff;
   logic                    rsp_found_ff;
   logic                    rsp_ovf_ff;

   logic [PB-1:0] prio_masked;
   logic          store_ok;
   logic          issue;
   logic          eval;
   logic [IW-1:0] head_after;
   logic [RW-1:0] rank_wide;

   always_comb begin
      prio_masked = '0;
      for (int i = 0; i < PB; i++) begin
         if (i < PRIO_FIELD_W) begin
            prio_masked[i] = req_job_priority[i];
         end
      end
   end

   assign store_ok = job_count_ff < CW'(MAX_JOBS);
   assign issue    = cmd.scan && !hit_ff && (issued_ff < job_count_ff);
   assign eval     = cmd.scan && !hit_ff && rd_vld_ff;

   // head moves to the slot after the last job served at the closing level
   assign head_after = ((CW'(last_ff) + CW'(1)) == job_count_ff) ? '0 : last_ff + IW'(1);

   always_ff @(posedge clock) begin
      if (cmd.load && store_ok) begin
         mem[job_count_ff[IW-1:0]] <= prio_masked;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= mem[ptr_ff];
         rd_slot_ff <= ptr_ff;
      end
   end

   always_comb begin
      job_count_in   = job_count_ff;
      target_slot_in = target_slot_ff;
      target_seen_in = target_seen_ff;
      overflow_in    = overflow_ff;
      ptr_in         = ptr_ff;
      issued_in      = issued_ff;
      rd_vld_in      = issue;
      first_in       = first_ff;
      level_in       = level_ff;
      have_next_in   = have_next_ff;
      next_in        = next_ff;
      head_in        = head_ff;
      last_in        = last_ff;
      lvl_cnt_in     = lvl_cnt_ff;
      served_in      = served_ff;
      hit_in         = hit_ff;
      rank_in        = rank_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      if (cmd.load) begin
         if (store_ok) begin
            if (req_is_target) begin
               target_slot_in = job_count_ff[IW-1:0];
               target_seen_in = 1'b1;
            end
            job_count_in = job_count_ff + CW'(1);
         end else begin
            overflow_in = 1'b1;
         end
      end

      if (cmd.init) begin
         ptr_in       = '0;
         issued_in    = '0;
         rd_vld_in    = 1'b0;
         first_in     = 1'b1;
         have_next_in = 1'b0;
         head_in      = '0;
         lvl_cnt_in   = '0;
         served_in    = '0;
         hit_in       = 1'b0;
         rank_in      = '0;
      end

      if (issue) begin
         ptr_in    = ((CW'(ptr_ff) + CW'(1)) == job_count_ff) ? '0 : ptr_ff + IW'(1);
         issued_in = issued_ff + CW'(1);
      end

      if (eval) begin
         if (!first_ff && (rd_data_ff == level_ff)) begin
            lvl_cnt_in = lvl_cnt_ff + CW'(1);
            last_in    = rd_slot_ff;
            if (rd_slot_ff == target_slot_ff) begin
               hit_in  = 1'b1;
               rank_in = served_ff + lvl_cnt_ff + CW'(1);
            end
         end else if (first_ff || (rd_data_ff < level_ff)) begin
            // highest priority still below the current level, or overall on the first pass
            if (!have_next_ff || (rd_data_ff > next_ff)) begin
               next_in      = rd_data_ff;
               have_next_in = 1'b1;
            end
         end
      end

      if (cmd.step) begin
         level_in     = next_ff;
         have_next_in = 1'b0;
         first_in     = 1'b0;
         served_in    = served_ff + lvl_cnt_ff;
         lvl_cnt_in   = '0;
         issued_in    = '0;
         head_in      = first_ff ? head_ff : head_after;
         ptr_in       = first_ff ? head_ff : head_after;
      end

      if (cmd.capture) begin
         rsp_valid_in   = 1'b1;
         job_count_in   = '0;
         target_slot_in = '0;
         target_seen_in = 1'b0;
         overflow_in    = 1'b0;
         issued_in      = '0;
      end
   end

   assign rank_wide = RW'(rank_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         job_count_ff   <= '0;
         target_slot_ff <= '0;
         target_seen_ff <= 1'b0;
         overflow_ff    <= 1'b0;
         issued_ff      <= '0;
         rd_vld_ff      <= 1'b0;
         hit_ff         <= 1'b0;
         first_ff       <= 1'b1;
         have_next_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         job_count_ff   <= job_count_in;
         target_slot_ff <= target_slot_in;
         target_seen_ff <= target_seen_in;
         overflow_ff    <= overflow_in;
         issued_ff      <= issued_in;
         rd_vld_ff      <= rd_vld_in;
         hit_ff         <= hit_in;
         first_ff       <= first_in;
         have_next_ff   <= have_next_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      level_ff   <= level_in;
      next_ff    <= next_in;
      head_ff    <= head_in;
      last_ff    <= last_in;
      lvl_cnt_ff <= lvl_cnt_in;
      served_ff  <= served_in;
      rank_ff    <= rank_in;
      if (cmd.capture) begin
         rsp_rank_ff  <= (hit_ff && target_seen_ff)
                         ? ((rank_wide > RW'(255)) ? 8'd255 : rank_wide[RANK_FIELD_W-1:0])
                         : '0;
         rsp_found_ff <= target_seen_ff;
         rsp_ovf_ff   <= overflow_ff;
      end
   end

   assign sts.target_seen = target_seen_ff;
   assign sts.pass_done   = (issued_ff == job_count_ff) && !rd_vld_ff;
   assign sts.hit         = hit_ff;
   assign sts.no_next     = !have_next_ff;
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_service_rank = rsp_rank_ff;
   assign rsp_target_found = rsp_found_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (job_count_ff <= CW'(MAX_JOBS)) && (issued_ff <= job_count_ff))
      else $error("job or scan count out of range");

   a_read_in_set: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (CW'(rd_slot_ff) < job_count_ff))
      else $error("scan read outside the loaded jobs");

   a_hit_in_level_pass: assert property (@(posedge clock) disable iff (reset)
      $rose(hit_ff) |-> (!first_ff && (rank_ff != '0)))
      else $error("target served without a rank");

   a_target_in_set: assert property (@(posedge clock) disable iff (reset)
      target_seen_ff |-> (CW'(target_slot_ff) < job_count_ff))
      else $error("marked slot beyond loaded jobs");

endmodule : prsr_datapath
`default_nettype wire

// ----- src/priority_rotation_service_rank_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// priority_rotation_service_rank_unit
// service rank of a marked job under strict priority with round-robin ties
// ---------------------------------------------------------------------------
// Jobs load one request per cycle into a circular queue of MAX_JOBS slots;
// jobs past capacity are dropped and reported through rsp_overflow. The
// request flagged last_job starts the ranking, during which req_stall is
// high. The ranking runs one pass over the n loaded jobs through the single
// read port of the priority store to find the top priority, then one pass per
// distinct priority level down to the marked job's level. Within a level,
// jobs are served in slot order from the slot after the last job served at
// the level above. With no marked job no pass runs and the result carries
// rank 0. The result sits in an output register, so loading of the next set
// proceeds while it waits to be taken; a finished ranking waits until that
// register is free. Ranks above 255 read 255.
// ---------------------------------------------------------------------------
module priority_rotation_service_rank_unit #(
   parameter int MAX_JOBS      = prsr_pkg::MAX_JOBS_DEF,
   parameter int PRIORITY_BITS = prsr_pkg::PRIORITY_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [prsr_pkg::PRIO_FIELD_W-1:0] req_job_priority,
   input  wire logic                              req_is_target,
   input  wire logic                              req_last_job,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [prsr_pkg::RANK_FIELD_W-1:0]      rsp_service_rank,
   output logic                                   rsp_target_found,
   output logic                                   rsp_overflow
);
   import prsr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   prsr_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_last_job (req_last_job),
      .req_stall    (req_stall),
      .sts          (sts),
      .cmd          (cmd)
   );

   prsr_datapath #(
      .MAX_JOBS      (MAX_JOBS),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_job_priority (req_job_priority),
      .req_is_target    (req_is_target),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_service_rank (rsp_service_rank),
      .rsp_target_found (rsp_target_found),
      .rsp_overflow     (rsp_overflow)
   );

endmodule : priority_rotation_service_rank_unit
`default_nettype wire

// ----- bench/priority_rotation_service_rank_unit_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// priority_rotation_service_rank_unit_tb
// self-checking bench: job sets of varied size, priority spread and marking
// are loaded under random gaps and stalls, including a long output hold-off
// that backs up the block, and every rank is checked against a behavioral
// replay of the strict-priority, round-robin service order of the same set
// ---------------------------------------------------------------------------
module priority_rotation_service_rank_unit_tb;

   localparam int JOB_SLOTS        = prsr_pkg::MAX_JOBS_DEF;
   localparam int PRIO_W           = prsr_pkg::PRIO_FIELD_W;
   localparam int RANK_W           = prsr_pkg::RANK_FIELD_W;
   localparam int TARGET_REQUESTS  = 1050;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES     = 50;
   localparam int WATCHDOG_LIMIT   = 100000;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic              found;
      logic              overflow;
   } rank_result_type;

   class service_rank_board;
      logic [PRIO_W-1:0] stored_prio [JOB_SLOTS];
      int unsigned       stored_count;
      int unsigned       marked_slot;
      bit                marked_seen;
      bit                jobs_dropped;
      rank_result_type   expected_ranks [$];
      int unsigned       mismatches;

      task report_mismatch(input string what);
         mismatches++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      // serve the loaded set one job at a time until the marked job comes up
      function int unsigned serve_until_marked();
         bit                taken [JOB_SLOTS];
         int unsigned       n_served;
         int unsigned       head;
         int unsigned       pick;
         int unsigned       slot;
         logic [PRIO_W-1:0] top;
         bit                any;
         foreach (taken[k]) taken[k] = 1'b0;
         n_served = 0;
         head = 0;
         while (n_served < stored_count) begin
            any = 1'b0;
            top = '0;
            for (int k = 0; k < stored_count; k++) begin
               if (!taken[k] && (!any || stored_prio[k] > top)) begin
                  top = stored_prio[k];
                  any = 1'b1;
               end
            end
            // first pending job at the top level, circular from the head
            pick = stored_count;
            for (int k = 0; k < stored_count; k++) begin
               slot = head + k;
               if (slot >= stored_count) slot -= stored_count;
               if (!taken[slot] && stored_prio[slot] == top) begin
                  pick = slot;
                  break;
               end
            end
            taken[pick] = 1'b1;
            n_served++;
            head = (pick + 1 >= stored_count) ? 0 : pick + 1;
            if (pick == marked_slot) begin
               return (n_served > 255) ? 255 : n_served;
            end
         end
         return 0;
      endfunction

      function void note_request(input logic [PRIO_W-1:0] prio, input logic mark,
                                 input logic last);
         rank_result_type r;
         if (stored_count < JOB_SLOTS) begin
            stored_prio[stored_count] = prio;
            if (mark) begin
               marked_slot = stored_count;
               marked_seen = 1'b1;
            end
            stored_count++;
         end else begin
            jobs_dropped = 1'b1;
         end
         if (last) begin
            r.rank     = marked_seen ? RANK_W'(serve_until_marked()) : '0;
            r.found    = marked_seen;
            r.overflow = jobs_dropped;
            expected_ranks.insert(expected_ranks.size(), r);
            stored_count = 0;
            marked_slot  = 0;
            marked_seen  = 1'b0;
            jobs_dropped = 1'b0;
         end
      endfunction

      task check_result(input logic [RANK_W-1:0] rank, input logic found,
                        input logic overflow);
         rank_result_type want;
         if (expected_ranks.size() == 0) begin
            report_mismatch($sformatf("unexpected result: rank %0d found %b overflow %b",
                                      rank, found, overflow));
         end else begin
            want = expected_ranks.pop_front();
            if (rank !== want.rank) begin
               report_mismatch($sformatf("service_rank %0d, expected %0d",
                                         rank, want.rank));
            end
            if (found !== want.found) begin
               report_mismatch($sformatf("target_found %b, expected %b",
                                         found, want.found));
            end
            if (overflow !== want.overflow) begin
               report_mismatch($sformatf("overflow %b, expected %b",
                                         overflow, want.overflow));
            end
         end
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [PRIO_W-1:0] req_job_priority;
   logic              req_is_target;
   logic              req_last_job;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [RANK_W-1:0] rsp_service_rank;
   logic              rsp_target_found;
   logic              rsp_overflow;

   service_rank_board ranks = new;

   int unsigned requests_sent  = 0;
   bit          sender_gapless = 1'b0;
   int unsigned results_taken  = 0;
   int unsigned take_wait      = 0;
   int unsigned long_hold      = 0;
   int unsigned burst_left     = 0;
   int unsigned idle_cycles    = 0;

   priority_rotation_service_rank_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_job_priority (req_job_priority),
      .req_is_target    (req_is_target),
      .req_last_job     (req_last_job),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_service_rank (rsp_service_rank),
      .rsp_target_found (rsp_target_found),
      .rsp_overflow     (rsp_overflow)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   task automatic send_job(input logic [PRIO_W-1:0] prio, input logic mark,
                           input logic last);
      int gap;
      gap = sender_gapless ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_job_priority <= prio;
      req_is_target    <= mark;
      req_last_job     <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ranks.note_request(prio, mark, last);
      requests_sent++;
   endtask

   task automatic send_random_set();
      int size;
      int lo;
      int hi;
      int marked_pos;
      bit has_target;
      bit extra_marks;
      bit mark;
      case ($urandom_range(0, 19))
         0: begin
            size = $urandom_range(120, 140);
         end
         1, 2: begin
            size = $urandom_range(13, 40);
         end
         default: begin
            size = $urandom_range(1, 12);
         end
      endcase
      // narrow spreads give long runs of ties, wide ones many levels
      lo = $urandom_range(0, 15);
      hi = $urandom_range(lo, 15);
      if ($urandom_range(0, 3) == 0) begin
         lo = 0;
         hi = 15;
      end
      has_target     = ($urandom_range(0, 7) != 0);
      extra_marks    = ($urandom_range(0, 4) == 0);
      marked_pos     = $urandom_range(0, size - 1);
      sender_gapless = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < size; i++) begin
         mark = (has_target && i == marked_pos) ||
                (extra_marks && $urandom_range(0, 5) == 0);
         send_job(PRIO_W'($urandom_range(lo, hi)), mark, i == size - 1);
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_job_priority <= '0;
      req_is_target    <= 1'b0;
      req_last_job     <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // single job sets, marked and unmarked
      send_job(4'd15, 1'b1, 1'b1);
      send_job(4'd0, 1'b0, 1'b1);
      // marked job second at its level, behind a higher one
      send_job(4'd3, 1'b0, 1'b0);
      send_job(4'd7, 1'b0, 1'b0);
      send_job(4'd7, 1'b1, 1'b0);
      send_job(4'd15, 1'b0, 1'b1);
      // several marks: the later stored one counts
      send_job(4'd0, 1'b1, 1'b0);
      send_job(4'd15, 1'b0, 1'b0);
      send_job(4'd0, 1'b0, 1'b0);
      send_job(4'd15, 1'b1, 1'b0);
      send_job(4'd0, 1'b0, 1'b1);
      // ties that wrap round behind the head
      send_job(4'd5, 1'b0, 1'b0);
      send_job(4'd5, 1'b1, 1'b0);
      send_job(4'd9, 1'b0, 1'b0);
      send_job(4'd5, 1'b0, 1'b0);
      send_job(4'd5, 1'b0, 1'b1);
      // one level throughout, marked job first
      send_job(4'd15, 1'b1, 1'b0);
      send_job(4'd15, 1'b0, 1'b0);
      send_job(4'd15, 1'b0, 1'b0);
      send_job(4'd15, 1'b0, 1'b1);

      // full queue at one level, marked job served last
      for (int i = 0; i < JOB_SLOTS; i++) begin
         send_job(4'd9, i == JOB_SLOTS - 1, i == JOB_SLOTS - 1);
      end
      // past capacity: the second mark and the last flag land on dropped jobs
      for (int i = 0; i < JOB_SLOTS + 3; i++) begin
         send_job(PRIO_W'($urandom_range(0, 15)), i == 50 || i == JOB_SLOTS + 2,
                  i == JOB_SLOTS + 2);
      end

      while (requests_sent < TARGET_REQUESTS) send_random_set();
      req_valid <= 1'b0;

      while (ranks.expected_ranks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ranks.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // result side: per-result wait, short stall-free bursts, two long hold-offs
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            ranks.check_result(rsp_service_rank, rsp_target_found, rsp_overflow);
            results_taken++;
            if (results_taken == 12 || results_taken == 45) begin
               long_hold = LONG_HOLD_CYCLES;
            end
            if (burst_left > 0) begin
               burst_left--;
               take_wait = 0;
            end else begin
               take_wait = $urandom_range(0, 3);
               if ($urandom_range(0, 9) == 0) burst_left = 10;
            end
         end else if (rsp_valid && take_wait > 0) begin
            take_wait--;
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (take_wait > 0);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] timeout: no request or result moved for %0d cycles",
                     $time, idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

endmodule

// ----- priority_rotation_service_rank_unit.f -----
src/prsr_pkg.sv
src/prsr_ctrl.sv
src/prsr_datapath.sv
src/priority_rotation_service_rank_unit.sv
bench/priority_rotation_service_rank_unit_tb.sv
